@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL file that carries checks.
// Expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/ttt_pkg.sv @@
// Shared types, constants and codes for the tank level trend tracker.
// No dependencies; every other file but the assertion macro header imports it.
`timescale 1ns / 1ps

package ttt_pkg;

  localparam int CODE_W     = 3;
  localparam int NUM_CODES  = 8;
  localparam int DIST_W     = 10;
  localparam int LEVEL_W    = 10;
  localparam int NIB_W      = 4;
  localparam int CFG_SLP_W  = 36;
  localparam int SLEEP_W    = 40;
  localparam int OUT_CNT_W  = 32;
  localparam int COUNT_W    = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [CFG_SLP_W-1:0] BACKUP_SLEEP_US = 36'd300000000;
  localparam logic [NIB_W-1:0]     WEAK_FACTOR     = 4'd2;
  localparam logic [NIB_W-1:0]     INVALID_FACTOR  = 4'd3;

  localparam logic [CODE_W-1:0] RC_OK   = 3'd0;
  localparam logic [CODE_W-1:0] RC_WEAK = 3'd1;

  typedef enum logic [1:0] {
    FS_UNKNOWN  = 2'd0,
    FS_STABLE   = 2'd1,
    FS_FILLING  = 2'd2,
    FS_DRAINING = 2'd3
  } fill_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DELTA_FLOOR       = 3'd0,
    REG_CONFIRMATIONS     = 3'd1,
    REG_FAILURE_THRESHOLD = 3'd2,
    REG_SLEEP_FILLING     = 3'd3,
    REG_SLEEP_DRAINING    = 3'd4,
    REG_SLEEP_STABLE      = 3'd5,
    REG_SLEEP_NIGHT       = 3'd6,
    REG_SLEEP_UNKNOWN     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   delta_floor;
    logic [NIB_W-1:0]     confirmations_needed;
    logic [NIB_W-1:0]     failure_threshold;
    logic [CFG_SLP_W-1:0] sleep_filling_us;
    logic [CFG_SLP_W-1:0] sleep_draining_us;
    logic [CFG_SLP_W-1:0] sleep_stable_us;
    logic [CFG_SLP_W-1:0] sleep_stable_night_us;
    logic [CFG_SLP_W-1:0] sleep_unknown_us;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0]  result_code;
    logic [DIST_W-1:0]  distance_cm;
    logic [LEVEL_W-1:0] level_pm;
    logic               night;
    logic               tank_full;
  } item_t;

endpackage

@@ rtl/ttt_intf.sv @@
// Valid/ready channel interfaces for sensor readings and tracker results.
// Depends on ttt_pkg for field widths.
`timescale 1ns / 1ps

interface ttt_in_if;
  import ttt_pkg::*;
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  result_code;
  logic [DIST_W-1:0]  distance_cm;
  logic [LEVEL_W-1:0] level_pm;
  logic               night;
  logic               tank_full;

  modport source (output valid, result_code, distance_cm, level_pm, night,
                  tank_full, input ready);
  modport sink (input valid, result_code, distance_cm, level_pm, night,
                tank_full, output ready);
endinterface

interface ttt_out_if;
  import ttt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           tank_state;
  logic [1:0]           pending_state;
  logic [NIB_W-1:0]     pending_count;
  logic [LEVEL_W-1:0]   level_out;
  logic [DIST_W-1:0]    distance_out;
  logic                 backup_mode;
  logic [NIB_W-1:0]     failure_streak;
  logic [SLEEP_W-1:0]   sleep_us;
  logic [OUT_CNT_W-1:0] reading_count;
  logic [OUT_CNT_W-1:0] code_count;

  modport source (output valid, tank_state, pending_state, pending_count, level_out,
                  distance_out, backup_mode, failure_streak, sleep_us, reading_count,
                  code_count, input ready);
  modport sink (input valid, tank_state, pending_state, pending_count, level_out,
                distance_out, backup_mode, failure_streak, sleep_us, reading_count,
                code_count, output ready);
endinterface

@@ rtl/ttt_cfg_regs.sv @@
// APB-style configuration register file for the trend tracker.
// Depends on ttt_pkg for the register map and cfg_t.
`timescale 1ns / 1ps

module ttt_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ttt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ttt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ttt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                         pready,
  output ttt_pkg::cfg_t                cfg
);
  import ttt_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delta_floor           <= 10'd10;
      cfg.confirmations_needed  <= 4'd3;
      cfg.failure_threshold     <= 4'd3;
      cfg.sleep_filling_us      <= 36'd60000000;
      cfg.sleep_draining_us     <= 36'd120000000;
      cfg.sleep_stable_us       <= 36'd600000000;
      cfg.sleep_stable_night_us <= 36'd1800000000;
      cfg.sleep_unknown_us      <= 36'd300000000;
    end else if (wr_en) begin
      case (idx)
        REG_DELTA_FLOOR:       cfg.delta_floor           <= pwdata[LEVEL_W-1:0];
        REG_CONFIRMATIONS:     cfg.confirmations_needed  <= pwdata[NIB_W-1:0];
        REG_FAILURE_THRESHOLD: cfg.failure_threshold     <= pwdata[NIB_W-1:0];
        REG_SLEEP_FILLING:     cfg.sleep_filling_us      <= pwdata[CFG_SLP_W-1:0];
        REG_SLEEP_DRAINING:    cfg.sleep_draining_us     <= pwdata[CFG_SLP_W-1:0];
        REG_SLEEP_STABLE:      cfg.sleep_stable_us       <= pwdata[CFG_SLP_W-1:0];
        REG_SLEEP_NIGHT:       cfg.sleep_stable_night_us <= pwdata[CFG_SLP_W-1:0];
        REG_SLEEP_UNKNOWN:     cfg.sleep_unknown_us      <= pwdata[CFG_SLP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DELTA_FLOOR:       prdata = CFG_DATA_W'(cfg.delta_floor);
      REG_CONFIRMATIONS:     prdata = CFG_DATA_W'(cfg.confirmations_needed);
      REG_FAILURE_THRESHOLD: prdata = CFG_DATA_W'(cfg.failure_threshold);
      REG_SLEEP_FILLING:     prdata = CFG_DATA_W'(cfg.sleep_filling_us);
      REG_SLEEP_DRAINING:    prdata = CFG_DATA_W'(cfg.sleep_draining_us);
      REG_SLEEP_STABLE:      prdata = CFG_DATA_W'(cfg.sleep_stable_us);
      REG_SLEEP_NIGHT:       prdata = CFG_DATA_W'(cfg.sleep_stable_night_us);
      REG_SLEEP_UNKNOWN:     prdata = CFG_DATA_W'(cfg.sleep_unknown_us);
      default:               prdata = '0;
    endcase
  end

endmodule

@@ rtl/ttt_tracker.sv @@
// Tracker state, single-pass update logic and result register.
// Depends on ttt_pkg and the ttt_out_if interface.
`timescale 1ns / 1ps

module ttt_tracker (
  input  logic           clk,
  input  logic           rst,
  input  ttt_pkg::cfg_t  cfg,
  input  logic           s1_valid,
  input  ttt_pkg::item_t s1_item,
  output logic           s1_take,
  ttt_out_if.source      result
);
  import ttt_pkg::*;

  fill_t              conf, conf_next;
  fill_t              cand, cand_next;
  fill_t              dir;
  logic [NIB_W-1:0]   cand_cnt, cand_cnt_next, cnt_inc;
  logic [LEVEL_W-1:0] prev_level, prev_level_next, mag;
  logic [DIST_W-1:0]  last_dist, last_dist_next;
  logic [NIB_W-1:0]   fail_cnt, fail_cnt_next;
  logic               backup, backup_next;
  logic [COUNT_W-1:0] total, total_next, code_cnt_next;
  logic [COUNT_W-1:0] code_cnt [NUM_CODES];
  logic               success;
  logic [CFG_SLP_W-1:0] stable_t, trend_t;
  logic [SLEEP_W-1:0] sleep_next;

  assign s1_take = s1_valid && (!result.valid || result.ready);

  assign success = (s1_item.result_code == RC_OK) || (s1_item.result_code == RC_WEAK);
  assign mag = (s1_item.level_pm >= prev_level) ? s1_item.level_pm - prev_level
                                                : prev_level - s1_item.level_pm;
  assign cnt_inc = cand_cnt + 4'd1;

  always_comb begin
    if (mag < cfg.delta_floor) begin
      dir = FS_STABLE;
    end else if (s1_item.level_pm > prev_level) begin
      dir = FS_FILLING;
    end else begin
      dir = FS_DRAINING;
    end
  end

  // Trend confirmation
  always_comb begin
    conf_next       = conf;
    cand_next       = cand;
    cand_cnt_next   = cand_cnt;
    prev_level_next = prev_level;
    last_dist_next  = last_dist;
    if (success) begin
      prev_level_next = s1_item.level_pm;
      last_dist_next  = s1_item.distance_cm;
      if (prev_level == '0) begin
        conf_next     = FS_STABLE;
        cand_next     = FS_UNKNOWN;
        cand_cnt_next = '0;
      end else if (conf == FS_UNKNOWN || dir == conf) begin
        conf_next     = dir;
        cand_next     = FS_UNKNOWN;
        cand_cnt_next = '0;
      end else if (dir == cand) begin
        if (cnt_inc >= cfg.confirmations_needed) begin
          conf_next     = dir;
          cand_next     = FS_UNKNOWN;
          cand_cnt_next = '0;
        end else begin
          cand_cnt_next = cnt_inc;
        end
      end else begin
        cand_next     = dir;
        cand_cnt_next = 4'd1;
      end
    end
  end

  // Failure streak with hysteresis on backup mode
  always_comb begin
    fail_cnt_next = fail_cnt;
    if (!success) begin
      if (fail_cnt < cfg.failure_threshold) begin
        fail_cnt_next = fail_cnt + 4'd1;
      end
    end else if (s1_item.result_code == RC_OK && fail_cnt != '0) begin
      fail_cnt_next = fail_cnt - 4'd1;
    end
    backup_next = backup;
    if (fail_cnt_next >= cfg.failure_threshold) begin
      backup_next = 1'b1;
    end else if ({1'b0, fail_cnt_next} + 5'd1 < {1'b0, cfg.failure_threshold}) begin
      backup_next = 1'b0;
    end
  end

  // Sleep interval
  assign stable_t = s1_item.night ? cfg.sleep_stable_night_us : cfg.sleep_stable_us;

  always_comb begin
    case (conf_next)
      FS_FILLING:  trend_t = cfg.sleep_filling_us;
      FS_DRAINING: trend_t = cfg.sleep_draining_us;
      FS_STABLE:   trend_t = stable_t;
      default:     trend_t = cfg.sleep_unknown_us;
    endcase
    if (backup_next) begin
      sleep_next = SLEEP_W'(s1_item.tank_full ? stable_t : BACKUP_SLEEP_US);
    end else if (success) begin
      if (s1_item.result_code == RC_WEAK) begin
        sleep_next = SLEEP_W'(trend_t) * SLEEP_W'(WEAK_FACTOR);
      end else begin
        sleep_next = SLEEP_W'(trend_t);
      end
    end else begin
      sleep_next = SLEEP_W'(cfg.sleep_unknown_us) * SLEEP_W'(INVALID_FACTOR);
    end
  end

  assign total_next    = total + COUNT_W'(1);
  assign code_cnt_next = code_cnt[s1_item.result_code] + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      conf       <= FS_UNKNOWN;
      cand       <= FS_UNKNOWN;
      cand_cnt   <= '0;
      prev_level <= '0;
      last_dist  <= '0;
      fail_cnt   <= '0;
      backup     <= 1'b0;
      total      <= '0;
      for (int i = 0; i < NUM_CODES; i++) begin
        code_cnt[i] <= '0;
      end
    end else if (s1_take) begin
      conf       <= conf_next;
      cand       <= cand_next;
      cand_cnt   <= cand_cnt_next;
      prev_level <= prev_level_next;
      last_dist  <= last_dist_next;
      fail_cnt   <= fail_cnt_next;
      backup     <= backup_next;
      total      <= total_next;
      code_cnt[s1_item.result_code] <= code_cnt_next;
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      result.tank_state     <= conf_next;
      result.pending_state  <= cand_next;
      result.pending_count  <= cand_cnt_next;
      result.level_out      <= prev_level_next;
      result.distance_out   <= last_dist_next;
      result.backup_mode    <= backup_next;
      result.failure_streak <= fail_cnt_next;
      result.sleep_us       <= sleep_next;
      result.reading_count  <= OUT_CNT_W'(total_next);
      result.code_count     <= OUT_CNT_W'(code_cnt_next);
    end
  end

endmodule

@@ rtl/tank_level_trend_tracker.sv @@
// Tank level trend tracker: an accepted reading is held in the input register and then
// loaded into the result register, where its result word is valid. Throughput is one
// reading per cycle while the result side is ready; the input register and the result
// register each hold one word, so a reading can be taken while a finished result waits.
// Synchronous active-high reset clears all counters, trend and backup state, both
// valid flags, and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tank_level_trend_tracker (
  input  logic                           clk,
  input  logic                           rst,
  ttt_in_if.sink                         reading,
  ttt_out_if.source                      result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ttt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ttt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ttt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import ttt_pkg::*;

  cfg_t  cfg;
  item_t s1_item;
  logic  s1_valid;
  logic  s1_take;
  logic  res_unknown;
  logic  res_no_cand;
  logic  in_stalled;
  logic  pipe_empty;

  ttt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register: refill when empty or whenever the held word moves on
  assign reading.ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (reading.ready) begin
      s1_valid <= reading.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (reading.valid && reading.ready) begin
      s1_item.result_code <= reading.result_code;
      s1_item.distance_cm <= reading.distance_cm;
      s1_item.level_pm    <= reading.level_pm;
      s1_item.night       <= reading.night;
      s1_item.tank_full   <= reading.tank_full;
    end
  end

  ttt_tracker u_tracker (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take),
    .result   (result)
  );

  assign res_unknown = result.valid && (result.tank_state == FS_UNKNOWN);
  assign res_no_cand = (result.pending_state == FS_UNKNOWN) && (result.pending_count == '0);
  assign in_stalled  = s1_valid && result.valid && !result.ready;
  assign pipe_empty  = !s1_valid && !result.valid;

  `ASSERT_CLK(a_unknown_idle, res_unknown |-> res_no_cand, "candidate while state unknown")
  `ASSERT_CLK(a_stall_blocks_input, in_stalled |-> !reading.ready, "input taken while stalled")
  `ASSERT_ALWAYS(a_reset_empties, $past(rst) |-> pipe_empty, "not empty after reset")

endmodule
